/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define HSV2RGB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Implication: whenever ante holds, cons must hold in the same cycle.
`define HSV2RGB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* sv/hsv2rgb_pkg.sv */
`default_nettype none

package hsv2rgb_pkg;

	localparam int HUE_W   = 16;
	localparam int PCT_W   = 15;
	localparam int FRAC_W  = 10;
	localparam int TERM_W  = 25;
	localparam int PROD_W  = 40;
	localparam int ACC_W   = 44;
	localparam int Z_W     = 18;
	localparam int CHAN_W  = 8;
	localparam int LANES   = 3;
	localparam int COLOR_W = CHAN_W * LANES;

	localparam int HUE_FULL = 5760;
	localparam int SECTORS  = 6;

	// Lanes of a packed color: red in the top byte.
	localparam int LANE_R = 2;
	localparam int LANE_G = 1;
	localparam int LANE_B = 0;

	// Bias that makes every signed hue positive while keeping it congruent mod 5760.
	localparam logic [HUE_W:0] HUE_BIAS = (HUE_W + 1)'(SECTORS * HUE_FULL);

	// 960 = 64 * 15: drop six bits, then divide by 15 through a reciprocal.
	localparam int COARSE_SHIFT = 6;
	localparam int COARSE_W     = HUE_W + 1 - COARSE_SHIFT;
	localparam int KPROD_W      = 23;
	localparam int K_W          = 7;
	localparam logic [KPROD_W-1:0] RECIP15 = KPROD_W'(4370);
	localparam logic [COARSE_W-1:0] COARSE_DIV = COARSE_W'(15);
	localparam logic [11:0] RECIP6 = 12'd43;

	localparam logic [PCT_W-1:0]  PCT_FULL    = 15'd25600;
	localparam logic [FRAC_W-1:0] SECTOR_SPAN = 10'd960;
	localparam logic [TERM_W-1:0] TERM_FULL   = 25'd24576000;

	// channel = floor(17 * V * M / (625 * 2^26)); 1/625 ~ RECIP625 / 2^27
	localparam int SCALE_SHIFT  = 26;
	localparam int RECIP_SHIFT  = 27;
	localparam int RPROD_W      = 36;
	localparam logic [RPROD_W-1:0] RECIP625 = RPROD_W'(214749);
	localparam logic [Z_W-1:0] Z_LIMIT = Z_W'(160000);

	typedef enum logic [2:0] {
		SEC_RED_YELLOW   = 3'd0,
		SEC_YELLOW_GREEN = 3'd1,
		SEC_GREEN_CYAN   = 3'd2,
		SEC_CYAN_BLUE    = 3'd3,
		SEC_BLUE_MAGENTA = 3'd4,
		SEC_MAGENTA_RED  = 3'd5
	} sector_t;

	typedef struct packed {
		logic signed [HUE_W-1:0] hue_sixteenths;
		logic [PCT_W-1:0]        saturation_q8;
		logic [PCT_W-1:0]        brightness_q8;
	} hsv_t;

	typedef struct packed {
		sector_t           sector;
		logic [FRAC_W-1:0] frac;
		logic [PCT_W-1:0]  sat;
		logic [PCT_W-1:0]  val;
	} split_t;

	typedef struct packed {
		sector_t           sector;
		logic [TERM_W-1:0] tp;
		logic [TERM_W-1:0] tq;
		logic [TERM_W-1:0] tt;
		logic [PCT_W-1:0]  val;
	} terms_t;

endpackage

`default_nettype wire

/* sv/hsv2rgb_hsv_if.sv */
`default_nettype none

interface hsv2rgb_hsv_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [hsv2rgb_pkg::HUE_W-1:0]  hue_sixteenths;
	logic [hsv2rgb_pkg::PCT_W-1:0]         saturation_q8;
	logic [hsv2rgb_pkg::PCT_W-1:0]         brightness_q8;

	modport source (output valid, hue_sixteenths, saturation_q8, brightness_q8, input ready);
	modport sink (input valid, hue_sixteenths, saturation_q8, brightness_q8, output ready);
endinterface

`default_nettype wire

/* sv/hsv2rgb_rgb_if.sv */
`default_nettype none

interface hsv2rgb_rgb_if;
	logic                              valid;
	logic                              ready;
	logic [hsv2rgb_pkg::COLOR_W-1:0]   packed_color;

	modport source (output valid, packed_color, input ready);
	modport sink (input valid, packed_color, output ready);
endinterface

`default_nettype wire

/* sv/hsv2rgb_hue_split.sv */
`default_nettype none
`include "assert_macros.svh"

module hsv2rgb_hue_split (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire hsv2rgb_pkg::hsv_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output hsv2rgb_pkg::split_t      out_data
);

	logic [hsv2rgb_pkg::HUE_W:0]         biased;
	logic [hsv2rgb_pkg::KPROD_W-1:0]     kprod;
	logic [hsv2rgb_pkg::PCT_W-1:0]       sat_clip;
	logic [hsv2rgb_pkg::PCT_W-1:0]       val_clip;

	logic                                v_s1;
	logic [hsv2rgb_pkg::K_W-1:0]         k_s1;
	logic [hsv2rgb_pkg::COARSE_W-1:0]    coarse_s1;
	logic [hsv2rgb_pkg::COARSE_SHIFT-1:0] fine_s1;
	logic [hsv2rgb_pkg::PCT_W-1:0]       sat_s1;
	logic [hsv2rgb_pkg::PCT_W-1:0]       val_s1;

	logic [hsv2rgb_pkg::COARSE_W-1:0]    rem_full;
	logic [11:0]                         q6prod;
	logic [hsv2rgb_pkg::K_W-1:0]         sec_full;

	logic                                v_s2;
	hsv2rgb_pkg::split_t                 split_s2;

	logic                                en_s1;
	logic                                en_s2;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// Stage 1: bias hue positive, count 960-wide steps, clip percentages.
	always_comb begin
		biased = {in_data.hue_sixteenths[hsv2rgb_pkg::HUE_W-1], in_data.hue_sixteenths}
			+ hsv2rgb_pkg::HUE_BIAS;
		kprod  = hsv2rgb_pkg::KPROD_W'(biased[hsv2rgb_pkg::HUE_W:hsv2rgb_pkg::COARSE_SHIFT])
			* hsv2rgb_pkg::RECIP15;
		sat_clip = (in_data.saturation_q8 > hsv2rgb_pkg::PCT_FULL) ?
			hsv2rgb_pkg::PCT_FULL : in_data.saturation_q8;
		val_clip = (in_data.brightness_q8 > hsv2rgb_pkg::PCT_FULL) ?
			hsv2rgb_pkg::PCT_FULL : in_data.brightness_q8;
	end

	// Stage 2: fraction within the step, step count mod 6 gives the sector.
	always_comb begin
		rem_full = coarse_s1 - hsv2rgb_pkg::COARSE_W'(k_s1) * hsv2rgb_pkg::COARSE_DIV;
		q6prod   = 12'(k_s1) * hsv2rgb_pkg::RECIP6;
		sec_full = k_s1 - hsv2rgb_pkg::K_W'(q6prod[11:8]) * hsv2rgb_pkg::K_W'(hsv2rgb_pkg::SECTORS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			k_s1      <= kprod[hsv2rgb_pkg::KPROD_W-1:16];
			coarse_s1 <= biased[hsv2rgb_pkg::HUE_W:hsv2rgb_pkg::COARSE_SHIFT];
			fine_s1   <= biased[hsv2rgb_pkg::COARSE_SHIFT-1:0];
			sat_s1    <= sat_clip;
			val_s1    <= val_clip;
		end
		if (en_s2 && v_s1) begin
			split_s2.sector <= hsv2rgb_pkg::sector_t'(sec_full[2:0]);
			split_s2.frac   <= {rem_full[3:0], fine_s1};
			split_s2.sat    <= sat_s1;
			split_s2.val    <= val_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = split_s2;

	`HSV2RGB_ASSERT_IMPL(a_split_range, clk, arst_n, v_s2,
		split_s2.sector <= hsv2rgb_pkg::SEC_MAGENTA_RED && split_s2.frac < hsv2rgb_pkg::SECTOR_SPAN,
		"hue split produced a sector or fraction out of range")

endmodule

`default_nettype wire

/* sv/hsv2rgb_terms.sv */
`default_nettype none
`include "assert_macros.svh"

module hsv2rgb_terms (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire hsv2rgb_pkg::split_t in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output hsv2rgb_pkg::terms_t      out_data
);

	logic [hsv2rgb_pkg::PCT_W-1:0]  sat_comp;
	logic [hsv2rgb_pkg::FRAC_W-1:0] frac_comp;
	logic [hsv2rgb_pkg::TERM_W-1:0] tp;
	logic [hsv2rgb_pkg::TERM_W-1:0] tq;
	logic [hsv2rgb_pkg::TERM_W-1:0] tt;

	logic                           v_s3;
	hsv2rgb_pkg::terms_t            terms_s3;
	logic                           en_s3;

	assign en_s3    = !v_s3 || out_ready;
	assign in_ready = en_s3;

	// Stage 3: p, q and t in units of 1/(25600*960).
	always_comb begin
		sat_comp  = hsv2rgb_pkg::PCT_FULL - in_data.sat;
		frac_comp = hsv2rgb_pkg::SECTOR_SPAN - in_data.frac;
		tp = hsv2rgb_pkg::TERM_W'(sat_comp) * hsv2rgb_pkg::TERM_W'(hsv2rgb_pkg::SECTOR_SPAN);
		tq = hsv2rgb_pkg::TERM_FULL
			- hsv2rgb_pkg::TERM_W'(in_data.frac) * hsv2rgb_pkg::TERM_W'(in_data.sat);
		tt = hsv2rgb_pkg::TERM_FULL
			- hsv2rgb_pkg::TERM_W'(frac_comp) * hsv2rgb_pkg::TERM_W'(in_data.sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			terms_s3.sector <= in_data.sector;
			terms_s3.tp     <= tp;
			terms_s3.tq     <= tq;
			terms_s3.tt     <= tt;
			terms_s3.val    <= in_data.val;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = terms_s3;

	`HSV2RGB_ASSERT(a_terms_range, clk, arst_n,
		!v_s3 || (terms_s3.tp <= hsv2rgb_pkg::TERM_FULL && terms_s3.tq <= hsv2rgb_pkg::TERM_FULL
		&& terms_s3.tt <= hsv2rgb_pkg::TERM_FULL),
		"p, q or t term exceeds full scale")

endmodule

`default_nettype wire

/* sv/hsv2rgb_scale.sv */
`default_nettype none
`include "assert_macros.svh"

module hsv2rgb_scale (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire hsv2rgb_pkg::terms_t              in_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [hsv2rgb_pkg::COLOR_W-1:0]       out_color
);

	logic [hsv2rgb_pkg::LANES-1:0][hsv2rgb_pkg::TERM_W-1:0]  pick;
	logic [hsv2rgb_pkg::LANES-1:0][hsv2rgb_pkg::ACC_W-1:0]   acc;
	logic [hsv2rgb_pkg::LANES-1:0][hsv2rgb_pkg::RPROD_W-1:0] rprod;

	logic                                                    v_s4;
	logic [hsv2rgb_pkg::LANES-1:0][hsv2rgb_pkg::PROD_W-1:0]  prod_s4;
	logic                                                    v_s5;
	logic [hsv2rgb_pkg::LANES-1:0][hsv2rgb_pkg::Z_W-1:0]     z_s5;
	logic                                                    v_s6;
	logic [hsv2rgb_pkg::LANES-1:0][hsv2rgb_pkg::CHAN_W-1:0]  ch_s6;

	logic en_s4;
	logic en_s5;
	logic en_s6;

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign in_ready = en_s4;

	// Stage 4: route v, p, q, t to the channels by sector.
	always_comb begin
		case (in_data.sector)
			hsv2rgb_pkg::SEC_RED_YELLOW: begin
				pick[hsv2rgb_pkg::LANE_R] = hsv2rgb_pkg::TERM_FULL;
				pick[hsv2rgb_pkg::LANE_G] = in_data.tt;
				pick[hsv2rgb_pkg::LANE_B] = in_data.tp;
			end
			hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
				pick[hsv2rgb_pkg::LANE_R] = in_data.tq;
				pick[hsv2rgb_pkg::LANE_G] = hsv2rgb_pkg::TERM_FULL;
				pick[hsv2rgb_pkg::LANE_B] = in_data.tp;
			end
			hsv2rgb_pkg::SEC_GREEN_CYAN: begin
				pick[hsv2rgb_pkg::LANE_R] = in_data.tp;
				pick[hsv2rgb_pkg::LANE_G] = hsv2rgb_pkg::TERM_FULL;
				pick[hsv2rgb_pkg::LANE_B] = in_data.tt;
			end
			hsv2rgb_pkg::SEC_CYAN_BLUE: begin
				pick[hsv2rgb_pkg::LANE_R] = in_data.tp;
				pick[hsv2rgb_pkg::LANE_G] = in_data.tq;
				pick[hsv2rgb_pkg::LANE_B] = hsv2rgb_pkg::TERM_FULL;
			end
			hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
				pick[hsv2rgb_pkg::LANE_R] = in_data.tt;
				pick[hsv2rgb_pkg::LANE_G] = in_data.tp;
				pick[hsv2rgb_pkg::LANE_B] = hsv2rgb_pkg::TERM_FULL;
			end
			default: begin
				pick[hsv2rgb_pkg::LANE_R] = hsv2rgb_pkg::TERM_FULL;
				pick[hsv2rgb_pkg::LANE_G] = in_data.tp;
				pick[hsv2rgb_pkg::LANE_B] = in_data.tq;
			end
		endcase
	end

	// Stage 5 times 17 and drop 2^26; stage 6 divides by 625 via reciprocal.
	always_comb begin
		for (int i = 0; i < hsv2rgb_pkg::LANES; i++) begin
			acc[i]   = {prod_s4[i], 4'b0000} + hsv2rgb_pkg::ACC_W'(prod_s4[i]);
			rprod[i] = hsv2rgb_pkg::RPROD_W'(z_s5[i]) * hsv2rgb_pkg::RECIP625;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s4) v_s4 <= in_valid;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < hsv2rgb_pkg::LANES; i++) begin
			if (en_s4 && in_valid)
				prod_s4[i] <= hsv2rgb_pkg::PROD_W'(in_data.val) * hsv2rgb_pkg::PROD_W'(pick[i]);
			if (en_s5 && v_s4)
				z_s5[i] <= acc[i][hsv2rgb_pkg::ACC_W-1:hsv2rgb_pkg::SCALE_SHIFT];
			if (en_s6 && v_s5)
				ch_s6[i] <= rprod[i][hsv2rgb_pkg::RECIP_SHIFT+hsv2rgb_pkg::CHAN_W-1:
					hsv2rgb_pkg::RECIP_SHIFT];
		end
	end

	assign out_valid = v_s6;
	assign out_color = ch_s6;

	// The reciprocal for 625 is exact only below 256 * 625.
	`HSV2RGB_ASSERT_IMPL(a_scale_range, clk, arst_n, v_s5,
		z_s5[0] < hsv2rgb_pkg::Z_LIMIT && z_s5[1] < hsv2rgb_pkg::Z_LIMIT
		&& z_s5[2] < hsv2rgb_pkg::Z_LIMIT,
		"scaled channel exceeds reciprocal range")

endmodule

`default_nettype wire

/* sv/hsv_to_packed_rgb_converter.sv */
// Channel  Dir  Payload                                         Width
// hsv      in   hue_sixteenths / saturation_q8 / brightness_q8  16s / 15 / 15
// rgb      out  packed_color (R 23:16, G 15:8, B 7:0)           24
//
// Throughput is one item per clock while rgb is not stalled; rgb.valid is the valid
// bit of the last stage, so a result leaves from the 1/625 reciprocal register.
// The six register stages: hue step reciprocal, sector and fraction fixup,
// p/q/t products, brightness product, 17x scale, and the 1/625 reciprocal.
// arst_n clears all stage valid bits; payload registers are not reset.
// A stage holds only when it is full and the stage after it is blocked, so bubbles
// close up and hsv.ready drops only when all six stages are full and rgb is stalled.
`default_nettype none

module hsv_to_packed_rgb_converter (
	input  wire logic    clk,
	input  wire logic    arst_n,
	hsv2rgb_hsv_if.sink  hsv,
	hsv2rgb_rgb_if.source rgb
);

	hsv2rgb_pkg::hsv_t   hsv_data;
	hsv2rgb_pkg::split_t split_data;
	hsv2rgb_pkg::terms_t terms_data;

	logic split_valid;
	logic split_ready;
	logic terms_valid;
	logic terms_ready;
	logic hsv_ready;
	logic rgb_valid;
	logic [hsv2rgb_pkg::COLOR_W-1:0] rgb_color;

	assign hsv_data.hue_sixteenths = hsv.hue_sixteenths;
	assign hsv_data.saturation_q8  = hsv.saturation_q8;
	assign hsv_data.brightness_q8  = hsv.brightness_q8;
	assign hsv.ready               = hsv_ready;

	hsv2rgb_hue_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hsv.valid),
		.in_ready  (hsv_ready),
		.in_data   (hsv_data),
		.out_valid (split_valid),
		.out_ready (split_ready),
		.out_data  (split_data)
	);

	hsv2rgb_terms u_terms (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (split_valid),
		.in_ready  (split_ready),
		.in_data   (split_data),
		.out_valid (terms_valid),
		.out_ready (terms_ready),
		.out_data  (terms_data)
	);

	hsv2rgb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (terms_valid),
		.in_ready  (terms_ready),
		.in_data   (terms_data),
		.out_valid (rgb_valid),
		.out_ready (rgb.ready),
		.out_color (rgb_color)
	);

	assign rgb.valid        = rgb_valid;
	assign rgb.packed_color = rgb_color;

endmodule

`default_nettype wire
